// File: rtl/ethernet_fcs_checker_with_dest_filter_assert.svh
// assertion macros for the assertion checker file
`ifndef ETHERNET_FCS_CHECKER_WITH_DEST_FILTER_ASSERT_SVH
`define ETHERNET_FCS_CHECKER_WITH_DEST_FILTER_ASSERT_SVH

// same-cycle implication
`define EFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("efc assertion failed");

// next-cycle implication
`define EFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("efc assertion failed");

`endif

// File: rtl/efc_pkg.sv
package efc_pkg;

	localparam int MAC_W = 48;
	localparam int ADDR_LEN = 6;
	localparam int FCS_LEN = 4;

	localparam logic [31:0] FCS_POLY = 32'hEDB8_8320;
	localparam logic [31:0] FCS_PRESET = 32'hFFFF_FFFF;

	typedef logic [7:0] byte_t;
	typedef logic [MAC_W-1:0] mac_t;
	// bytes seen in the frame, saturating
	typedef logic [2:0] count_t;

	localparam count_t CNT_MAX = 3'd7;

	// reflected crc-32, one byte, unrolled over its eight bits
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input byte_t b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ FCS_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/efc_if.sv
// frame byte channel
interface efc_frame_if;
	logic valid;
	logic ready;
	efc_pkg::byte_t data_byte;
	logic last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// per-frame status channel
interface efc_result_if;
	logic valid;
	logic ready;
	logic dest_match;
	logic fcs_ok;
	logic report;
	logic runt;

	modport source (output valid, output dest_match, output fcs_ok, output report,
		output runt, input ready);
	modport sink (input valid, input dest_match, input fcs_ok, input report,
		input runt, output ready);
endinterface

// station address write channel
interface efc_cfg_if;
	logic valid;
	logic ready;
	efc_pkg::mac_t station_mac;

	modport source (output valid, output station_mac, input ready);
	modport sink (input valid, input station_mac, output ready);
endinterface

// File: rtl/ethernet_fcs_checker_with_dest_filter.sv
// ethernet fcs checker with destination filter
// frame: one frame byte per transaction in wire order, last_byte set on the
//   final byte; the four trailing bytes are the received fcs
// result: one transaction per frame, issued for the byte with last_byte set:
//   dest_match, fcs_ok, report (addressed to us but corrupted) and runt
// cfg: writes the 48-bit station mac, first wire byte in bits 47..40;
//   always ready, write only while no frame is in flight
// throughput: one byte per cycle except while frame.ready is low (see stall);
//   the crc update is a byte-wide unrolled step that sits between the input
//   register and the frame state
// stall: the result register holds its transaction while result.ready is
//   low; non-final bytes keep flowing, and a final byte waits in the input
//   register, so frame.ready drops only while a result is stalled and a
//   second final byte is waiting behind it
// reset: arst_n presets the crc to all ones and the match flag to one, and
//   clears the tail window, the byte count, the station mac and all valid flags
module ethernet_fcs_checker_with_dest_filter (
	input logic clk,
	input logic arst_n,
	efc_cfg_if.sink cfg,
	efc_frame_if.sink frame,
	efc_result_if.source result
);

	// input register
	logic valid_s1;
	efc_pkg::byte_t data_s1;
	logic last_s1;

	// frame state
	logic [31:0] crc_q;
	efc_pkg::byte_t win_q [efc_pkg::FCS_LEN];
	efc_pkg::count_t cnt_q;
	logic match_q;
	efc_pkg::mac_t station_mac_q;

	// result register
	logic out_valid_q;
	logic dest_match_q;
	logic fcs_ok_q;
	logic report_q;
	logic runt_q;

	logic out_free;
	logic adv_s1;
	logic fire;
	efc_pkg::byte_t mac_byte;
	logic match_nxt;
	logic [31:0] crc_nxt;
	efc_pkg::count_t cnt_nxt;
	logic [31:0] rx_fcs;
	logic runt_c;
	logic dm_c;
	logic ok_c;

	// output slot can take a new result this cycle
	assign out_free = !out_valid_q || result.ready;
	// a non-final byte never needs the output slot
	assign adv_s1 = !last_s1 || out_free;
	assign fire = valid_s1 && adv_s1;

	assign frame.ready = !valid_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	// expected address byte at this position
	always_comb begin
		case (cnt_q)
			3'd0: mac_byte = station_mac_q[47:40];
			3'd1: mac_byte = station_mac_q[39:32];
			3'd2: mac_byte = station_mac_q[31:24];
			3'd3: mac_byte = station_mac_q[23:16];
			3'd4: mac_byte = station_mac_q[15:8];
			default: mac_byte = station_mac_q[7:0];
		endcase
	end

	always_comb begin
		match_nxt = match_q;
		if ((cnt_q < 3'(efc_pkg::ADDR_LEN)) && (data_s1 != mac_byte)) begin
			match_nxt = 1'b0;
		end
		// oldest window byte leaves into the crc once the window is full
		crc_nxt = (cnt_q >= 3'(efc_pkg::FCS_LEN)) ? efc_pkg::crc32_byte(crc_q, win_q[0])
			: crc_q;
		cnt_nxt = (cnt_q == efc_pkg::CNT_MAX) ? efc_pkg::CNT_MAX : cnt_q + 3'd1;
		// received fcs, earliest byte least significant
		rx_fcs = {data_s1, win_q[3], win_q[2], win_q[1]};
		runt_c = cnt_nxt < 3'(efc_pkg::FCS_LEN);
		dm_c = match_nxt && (cnt_nxt >= 3'(efc_pkg::ADDR_LEN));
		ok_c = !runt_c && ((~crc_nxt) == rx_fcs);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			data_s1 <= frame.data_byte;
			last_s1 <= frame.last_byte;
		end
	end

	// station address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_mac_q <= '0;
		end else if (cfg.valid) begin
			station_mac_q <= cfg.station_mac;
		end
	end

	// frame state, back to reset values after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= efc_pkg::FCS_PRESET;
			for (int i = 0; i < efc_pkg::FCS_LEN; i++) begin
				win_q[i] <= '0;
			end
			cnt_q <= '0;
			match_q <= 1'b1;
		end else if (fire) begin
			if (last_s1) begin
				crc_q <= efc_pkg::FCS_PRESET;
				for (int i = 0; i < efc_pkg::FCS_LEN; i++) begin
					win_q[i] <= '0;
				end
				cnt_q <= '0;
				match_q <= 1'b1;
			end else begin
				crc_q <= crc_nxt;
				for (int i = 0; i < efc_pkg::FCS_LEN - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[efc_pkg::FCS_LEN-1] <= data_s1;
				cnt_q <= cnt_nxt;
				match_q <= match_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			dest_match_q <= dm_c;
			fcs_ok_q <= ok_c;
			report_q <= dm_c && !ok_c;
			runt_q <= runt_c;
		end
	end

	assign result.valid = out_valid_q;
	assign result.dest_match = dest_match_q;
	assign result.fcs_ok = fcs_ok_q;
	assign result.report = report_q;
	assign result.runt = runt_q;

endmodule

// File: rtl/efc_assert_chk.sv
`include "ethernet_fcs_checker_with_dest_filter_assert.svh"

module efc_assert_chk (
	input logic clk,
	input logic arst_n,
	input logic frame_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_dest_match,
	input logic res_fcs_ok,
	input logic res_report,
	input logic res_runt
);

	logic [3:0] res_flags;

	assign res_flags = {res_dest_match, res_fcs_ok, res_report, res_runt};

	// input side only backs up behind a stalled result
	`EFC_ASSERT_IMPL(a_frame_stall, clk, arst_n, !frame_ready, res_valid && !res_ready)
	// a runt never matches and never passes the fcs
	`EFC_ASSERT_IMPL(a_runt_flags, clk, arst_n, res_valid && res_runt, res_flags[3:2] == 2'b00)
	// report is a matched frame with a bad fcs
	`EFC_ASSERT_IMPL(a_report, clk, arst_n, res_valid, res_report == (res_dest_match && !res_fcs_ok))
	// stalled result holds
	`EFC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_flags))

endmodule

bind ethernet_fcs_checker_with_dest_filter efc_assert_chk u_efc_assert_chk (
	.clk(clk),
	.arst_n(arst_n),
	.frame_ready(frame.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_dest_match(result.dest_match),
	.res_fcs_ok(result.fcs_ok),
	.res_report(result.report),
	.res_runt(result.runt)
);

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 10;
	// settle time after the last expected status has come back
	localparam int SETTLE_CYCLES = 4;
	// cycles with no transaction on any channel before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 60;
	localparam int PHASE_FRAMES = 3;
	localparam int NUM_PHASES = 6;
	localparam int MAX_SHOWN = 10;
	localparam int HEAVY_IDLE = 79;
	localparam int LIGHT_IDLE = 23;
	localparam int NO_IDLE = 0;

	typedef struct packed {
		logic dest_match;
		logic fcs_ok;
		logic report;
		logic runt;
	} status_t;

	// one directed byte; want is only used when typed is set
	typedef struct packed {
		efc_pkg::byte_t data;
		logic last;
		logic typed;
		status_t want;
	} row_t;

	localparam status_t NO_FLAGS = '0;
	localparam status_t RUNT_ONLY = '{dest_match: 1'b0, fcs_ok: 1'b0, report: 1'b0, runt: 1'b1};
	localparam status_t FCS_GOOD_ONLY = '{dest_match: 1'b0, fcs_ok: 1'b1, report: 1'b0,
		runt: 1'b0};
	localparam status_t HIT_CORRUPT = '{dest_match: 1'b1, fcs_ok: 1'b0, report: 1'b1,
		runt: 1'b0};

	// directed frames, run with the station mac still at its reset value of zero
	localparam int N_DIRECTED = 25;
	localparam row_t DIRECTED [N_DIRECTED] = '{
		// one-byte runt
		'{8'hFF, 1'b1, 1'b1, RUNT_ONLY},
		// two-byte runt
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'hFF, 1'b1, 1'b1, RUNT_ONLY},
		// three-byte runt
		'{8'h5A, 1'b0, 1'b0, NO_FLAGS},
		'{8'hA5, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b1, 1'b1, RUNT_ONLY},
		// four-byte frame: crc over nothing, so an all-zero fcs is good
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b1, 1'b1, FCS_GOOD_ONLY},
		// five-byte frame: all bytes match the mac but too short to hit
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b1, 1'b0, NO_FLAGS},
		// addressed to us with a broken fcs
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'h00, 1'b0, 1'b0, NO_FLAGS},
		'{8'hFF, 1'b0, 1'b0, NO_FLAGS},
		'{8'hFF, 1'b0, 1'b0, NO_FLAGS},
		'{8'hFF, 1'b0, 1'b0, NO_FLAGS},
		'{8'hFF, 1'b1, 1'b1, HIT_CORRUPT}
	};

	logic clk = 1'b0;
	logic arst_n;

	efc_frame_if frame_bus ();
	efc_result_if status_bus ();
	efc_cfg_if mac_bus ();

	ethernet_fcs_checker_with_dest_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(mac_bus),
		.frame(frame_bus),
		.result(status_bus)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// idle percentages, changed between phases
	int send_idle;
	int recv_idle;

	// frame status expected from the block, oldest first
	status_t pending_status[$];
	int mismatches;

	// shadow of the checker's frame state
	efc_pkg::mac_t station_addr;
	logic [31:0] run_crc;
	efc_pkg::byte_t tail [efc_pkg::FCS_LEN];
	efc_pkg::count_t seen;
	logic addr_ok;

	// frame under construction for the random part
	efc_pkg::byte_t frame_bytes[$];

	// reflected crc-32, one data bit at a time, lsb first
	function automatic logic [31:0] crc_step(input logic [31:0] c, input efc_pkg::byte_t b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ efc_pkg::FCS_POLY;
			end
		end
		return c;
	endfunction

	function automatic void clear_frame_state();
		run_crc = efc_pkg::FCS_PRESET;
		for (int k = 0; k < efc_pkg::FCS_LEN; k++) begin
			tail[k] = '0;
		end
		seen = '0;
		addr_ok = 1'b1;
	endfunction

	// advance the shadow state by one accepted byte; returns 1 when a status is due
	function automatic logic track_byte(input efc_pkg::byte_t b, input logic last,
		output status_t st);
		efc_pkg::count_t pos;
		logic [31:0] rx;
		pos = seen;
		st = NO_FLAGS;
		// address bytes compare against the mac, first wire byte in the top bits
		if (pos < efc_pkg::ADDR_LEN) begin
			if (b != station_addr[8 * (efc_pkg::ADDR_LEN - 1 - int'(pos)) +: 8]) begin
				addr_ok = 1'b0;
			end
		end
		// a byte only enters the crc once it drops out of the fcs window
		if (pos >= efc_pkg::FCS_LEN) begin
			run_crc = crc_step(run_crc, tail[0]);
		end
		for (int k = 0; k < efc_pkg::FCS_LEN - 1; k++) begin
			tail[k] = tail[k + 1];
		end
		tail[efc_pkg::FCS_LEN - 1] = b;
		seen = (pos < efc_pkg::CNT_MAX) ? pos + 3'd1 : efc_pkg::CNT_MAX;
		if (!last) begin
			return 1'b0;
		end
		// received fcs is little-endian: oldest window byte is the low byte
		rx = {tail[3], tail[2], tail[1], tail[0]};
		st.runt = (seen < efc_pkg::FCS_LEN);
		st.dest_match = addr_ok && (seen >= efc_pkg::ADDR_LEN);
		st.fcs_ok = !st.runt && (~run_crc == rx);
		st.report = st.dest_match && !st.fcs_ok;
		clear_frame_state();
		return 1'b1;
	endfunction

	function automatic efc_pkg::mac_t pick_mac(input int ph);
		logic [63:0] r;
		r = {$urandom, $urandom};
		case (ph)
			0: return '1;
			2: return '0;
			4: return 48'hAAAA_AAAA_AAAA;
			default: return r[efc_pkg::MAC_W-1:0];
		endcase
	endfunction

	// one frame byte transaction, called and returning at a falling edge
	task automatic push_byte(input efc_pkg::byte_t b, input logic last, input logic typed,
		input status_t want);
		status_t st;
		while ($urandom_range(99) < send_idle) begin
			frame_bus.valid <= 1'b0;
			@(negedge clk);
		end
		frame_bus.valid <= 1'b1;
		frame_bus.data_byte <= b;
		frame_bus.last_byte <= last;
		do @(posedge clk); while (!frame_bus.ready);
		if (track_byte(b, last, st)) begin
			pending_status.push_back(typed ? want : st);
		end
		@(negedge clk);
	endtask

	// hold off the sender until every status has come back, then let the block settle
	task automatic drain();
		frame_bus.valid <= 1'b0;
		while (pending_status.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mac(input efc_pkg::mac_t m);
		mac_bus.valid <= 1'b1;
		mac_bus.station_mac <= m;
		do @(posedge clk); while (!mac_bus.ready);
		station_addr = m;
		@(negedge clk);
		mac_bus.valid <= 1'b0;
	endtask

	// random frame: mostly well-formed with a good fcs, plus runts, noise,
	// near-miss and foreign addresses, and corrupted bits
	task automatic build_frame();
		int kind;
		int len;
		int idx;
		logic [31:0] crc;
		kind = $urandom_range(99);
		frame_bytes.delete();
		if (kind < 12) begin
			len = $urandom_range(5, 1);
			repeat (len) frame_bytes.push_back(efc_pkg::byte_t'($urandom));
			return;
		end
		if (kind < 20) begin
			len = $urandom_range(24, 6);
			repeat (len) frame_bytes.push_back(efc_pkg::byte_t'($urandom));
			return;
		end
		for (int k = 0; k < efc_pkg::ADDR_LEN; k++) begin
			frame_bytes.push_back(station_addr[8 * (efc_pkg::ADDR_LEN - 1 - k) +: 8]);
		end
		if (kind < 35) begin
			// one address bit off
			idx = $urandom_range(efc_pkg::ADDR_LEN - 1);
			frame_bytes[idx] = frame_bytes[idx] ^ efc_pkg::byte_t'(1 << $urandom_range(7));
		end else if (kind < 45) begin
			for (int k = 0; k < efc_pkg::ADDR_LEN; k++) begin
				frame_bytes[k] = efc_pkg::byte_t'($urandom);
			end
		end
		// now and then a long payload, so the byte counter sits in saturation for a long run
		len = ($urandom_range(19) == 0) ? $urandom_range(60, 40) : $urandom_range(14);
		repeat (len) frame_bytes.push_back(efc_pkg::byte_t'($urandom));
		crc = efc_pkg::FCS_PRESET;
		foreach (frame_bytes[k]) begin
			crc = crc_step(crc, frame_bytes[k]);
		end
		crc = ~crc;
		for (int k = 0; k < efc_pkg::FCS_LEN; k++) begin
			frame_bytes.push_back(crc[8 * k +: 8]);
		end
		if ($urandom_range(4) == 0) begin
			idx = $urandom_range(frame_bytes.size() - 1);
			frame_bytes[idx] = frame_bytes[idx] ^ efc_pkg::byte_t'(1 << $urandom_range(7));
		end
	endtask

	// status sink backpressure
	always @(negedge clk) begin
		status_bus.ready <= ($urandom_range(99) >= recv_idle);
	end

	// compare every status transaction with the oldest expectation
	always @(posedge clk) begin : status_check
		status_t want;
		if (arst_n && status_bus.valid && status_bus.ready) begin
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$display("%0t: frame status with none expected: ", $realtime,
						"dm=%0b ok=%0b rep=%0b runt=%0b",
						status_bus.dest_match, status_bus.fcs_ok,
						status_bus.report, status_bus.runt);
				end
			end else begin
				want = pending_status.pop_front();
				if (status_bus.dest_match !== want.dest_match
					|| status_bus.fcs_ok !== want.fcs_ok
					|| status_bus.report !== want.report
					|| status_bus.runt !== want.runt) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN) begin
						$display("%0t: frame status mismatch: ", $realtime,
							"expected dm=%0b ok=%0b rep=%0b runt=%0b, ",
							want.dest_match, want.fcs_ok, want.report, want.runt,
							"got dm=%0b ok=%0b rep=%0b runt=%0b",
							status_bus.dest_match, status_bus.fcs_ok,
							status_bus.report, status_bus.runt);
					end
				end
			end
		end
	end

	// hang detection: too long with no transaction on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((frame_bus.valid && frame_bus.ready) || (status_bus.valid && status_bus.ready)
				|| (mac_bus.valid && mac_bus.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		int items;
		int frames;
		// every input known from time zero, reset held low
		arst_n = 1'b0;
		frame_bus.valid = 1'b0;
		frame_bus.data_byte = '0;
		frame_bus.last_byte = 1'b0;
		mac_bus.valid = 1'b0;
		mac_bus.station_mac = '0;
		status_bus.ready = 1'b0;
		send_idle = LIGHT_IDLE;
		recv_idle = HEAVY_IDLE;
		mismatches = 0;
		station_addr = '0;
		clear_frame_state();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames against the reset mac
		for (int r = 0; r < N_DIRECTED; r++) begin
			push_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed,
				DIRECTED[r].want);
		end

		// random phases: new mac each phase, idling shifts every two phases
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			write_mac(pick_mac(ph));
			case (ph / 2)
				0: begin
					send_idle = LIGHT_IDLE;
					recv_idle = HEAVY_IDLE;
				end
				1: begin
					send_idle = HEAVY_IDLE;
					recv_idle = LIGHT_IDLE;
				end
				default: begin
					send_idle = NO_IDLE;
					recv_idle = NO_IDLE;
				end
			endcase
			items = 0;
			frames = 0;
			while (items < PHASE_ITEMS || frames < PHASE_FRAMES) begin
				build_frame();
				for (int k = 0; k < frame_bytes.size(); k++) begin
					push_byte(frame_bytes[k], k == frame_bytes.size() - 1, 1'b0, NO_FLAGS);
				end
				items += frame_bytes.size();
				frames++;
				// now and then let the result side empty out mid-phase
				if ($urandom_range(15) == 0) begin
					drain();
				end
			end
		end

		drain();
		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
